// ===== rtl/core/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants of the smoothed level meter with PWM alternator.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned SampleW   = 8;
  localparam int unsigned GainW     = 9;
  localparam int unsigned PhaseW    = 23;
  localparam int unsigned FiltW     = 16;
  localparam int unsigned LevelW    = 4;
  localparam int unsigned LampW     = 8;
  localparam int unsigned PwmCountW = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned GainShift = 8;
  localparam int unsigned NumLevels = 8;

  localparam logic [CfgIdxW-1:0] CfgSmoothingGain = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPhaseLength   = 2'd1;

  localparam logic [GainW-1:0]     GainMax    = 9'd256;
  localparam logic [GainW-1:0]     GainReset  = 9'd26;
  localparam logic [PhaseW-1:0]    PhaseReset = 23'd320000;
  localparam logic [FiltW-1:0]     FiltMax    = 16'hFFFF;
  localparam logic [PwmCountW-1:0] PwmLast    = 4'd7;

  localparam logic [SampleW-1:0] LevelThr [NumLevels] = '{
    8'd10, 8'd30, 8'd60, 8'd90, 8'd120, 8'd150, 8'd180, 8'd210
  };

  typedef struct packed {
    logic a;
    logic b;
  } drive_t;

endpackage

// ===== rtl/core/slm_filter.sv =====
// ----------------------------------------------------------------------------
// slm_filter
// Exponential average of the sample in unsigned fixed point, floored step.
// ----------------------------------------------------------------------------
module slm_filter import slm_pkg::*; #(
  parameter int unsigned FractionBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [GainW-1:0]   gain_i,
  output logic [FiltW-1:0]   next_o
);

  localparam int unsigned TargetW = SampleW + FractionBits;
  localparam int unsigned CmpW    = (TargetW > FiltW) ? TargetW : FiltW;
  localparam int unsigned DiffW   = CmpW + 1;
  localparam int unsigned ProdW   = DiffW + GainW + 1;
  localparam int unsigned SumW    = ProdW + 1;

  logic [FiltW-1:0]          filtered_q, filtered_d;
  logic [GainW-1:0]          gain_sat;
  logic [TargetW-1:0]        target;
  logic signed [DiffW-1:0]   diff;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   step;
  logic signed [SumW-1:0]    sum;

  assign gain_sat = (gain_i > GainMax) ? GainMax : gain_i;
  assign target   = TargetW'(sample_i) << FractionBits;
  assign diff     = $signed(DiffW'(target)) - $signed(DiffW'(filtered_q));
  assign prod     = $signed(ProdW'(gain_sat)) * ProdW'(diff);
  assign step     = prod >>> GainShift;
  assign sum      = $signed(SumW'(filtered_q)) + SumW'(step);

  always_comb begin
    if (sum < 0) begin
      filtered_d = '0;
    end else if (sum > $signed(SumW'(FiltMax))) begin
      filtered_d = FiltMax;
    end else begin
      filtered_d = sum[FiltW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filtered_q <= '0;
    end else if (en_i) begin
      filtered_q <= filtered_d;
    end
  end

  assign next_o = filtered_d;

endmodule

// ===== rtl/core/slm_level.sv =====
// ----------------------------------------------------------------------------
// slm_level
// Quantizes the average to a bar level and decodes the one-hot lamp pattern.
// ----------------------------------------------------------------------------
module slm_level import slm_pkg::*; #(
  parameter int unsigned FractionBits = 8
) (
  input  logic [FiltW-1:0]  filtered_i,
  output logic [LevelW-1:0] level_o,
  output logic [LampW-1:0]  lamps_o
);

  localparam int unsigned TargetW = SampleW + FractionBits;
  localparam int unsigned CmpW    = (TargetW > FiltW) ? TargetW : FiltW;

  always_comb begin
    level_o = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (CmpW'(filtered_i) > (CmpW'(LevelThr[i]) << FractionBits)) begin
        level_o = LevelW'(i + 1);
      end
    end
  end

  always_comb begin
    lamps_o = '0;
    if (level_o != '0) begin
      lamps_o = LampW'(1) << (level_o - LevelW'(1));
    end
  end

endmodule

// ===== rtl/core/slm_pwm.sv =====
// ----------------------------------------------------------------------------
// slm_pwm
// 4-bit PWM count, phase timer and the two alternating duty registers.
// ----------------------------------------------------------------------------
module slm_pwm import slm_pkg::*; #(
  parameter int unsigned TimerBits = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [LevelW-1:0] level_i,
  input  logic [PhaseW-1:0] phase_len_i,
  output drive_t            drive_o
);

  localparam int unsigned CmpW = (TimerBits > PhaseW + 1) ? TimerBits : PhaseW + 1;

  logic [PwmCountW-1:0] count_q, count_d, count_cur;
  logic [TimerBits-1:0] timer_q, timer_d, timer_cur;
  logic [LevelW-1:0]    duty_a_q, duty_a_d;
  logic [LevelW-1:0]    duty_b_q, duty_b_d;
  logic [CmpW-1:0]      span, span2, timer_ext;

  assign span      = CmpW'(phase_len_i);
  assign span2     = CmpW'({phase_len_i, 1'b0});
  assign timer_ext = CmpW'(timer_q);

  always_comb begin
    count_cur = count_q;
    timer_cur = timer_q;
    duty_a_d  = duty_a_q;
    duty_b_d  = duty_b_q;
    if (count_q > PwmLast) begin
      count_cur = '0;
      if (timer_ext <= span) begin
        duty_a_d = level_i;
        duty_b_d = '0;
      end else if (timer_ext <= span2) begin
        duty_b_d = level_i;
        duty_a_d = '0;
      end else begin
        timer_cur = '0;
      end
    end
    drive_o.a = (duty_a_d > count_cur);
    drive_o.b = (duty_b_d > count_cur);
    count_d   = count_cur + PwmCountW'(1);
    timer_d   = timer_cur + TimerBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      timer_q  <= '0;
      duty_a_q <= '0;
      duty_b_q <= '0;
    end else if (en_i) begin
      count_q  <= count_d;
      timer_q  <= timer_d;
      duty_a_q <= duty_a_d;
      duty_b_q <= duty_b_d;
    end
  end

endmodule

// ===== rtl/core/smoothed_level_meter_pwm_alternator.sv =====
// ----------------------------------------------------------------------------
// smoothed_level_meter_pwm_alternator
// Smoothed level meter with bar lamps and two alternating PWM drives.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   sample_i
//   out      output     out_valid_o/out_ready_i level_o lamp_bits_o drive_a_o
//                                               drive_b_o smoothed_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// one item per cycle while the result is not stalled; its result appears in the cycle after it is accepted
// the result is held in the single result register after the filter multiply
// reset clears the average, pwm state, duties and loads register defaults
// a stalled result holds; a new item is taken in the cycle the result leaves
// ----------------------------------------------------------------------------
module smoothed_level_meter_pwm_alternator import slm_pkg::*; #(
  parameter int unsigned FractionBits = 8,
  parameter int unsigned TimerBits    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [LevelW-1:0]  level_o,
  output logic [LampW-1:0]   lamp_bits_o,
  output logic               drive_a_o,
  output logic               drive_b_o,
  output logic [FiltW-1:0]   smoothed_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PhaseW-1:0]  cfg_data_i
);

  logic [GainW-1:0]  gain_q;
  logic [PhaseW-1:0] phase_q;
  logic              accept;
  logic [FiltW-1:0]  filt_next;
  logic [LevelW-1:0] level;
  logic [LampW-1:0]  lamps;
  drive_t            drive;

  logic              out_valid_q;
  logic [LevelW-1:0] level_q;
  logic [LampW-1:0]  lamps_q;
  drive_t            drive_q;
  logic [FiltW-1:0]  smoothed_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainReset;
      phase_q <= PhaseReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgSmoothingGain) begin
        gain_q <= cfg_data_i[GainW-1:0];
      end else if (cfg_index_i == CfgPhaseLength) begin
        phase_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  slm_filter #(
    .FractionBits(FractionBits)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .sample_i(sample_i),
    .gain_i  (gain_q),
    .next_o  (filt_next)
  );

  slm_level #(
    .FractionBits(FractionBits)
  ) u_level (
    .filtered_i(filt_next),
    .level_o   (level),
    .lamps_o   (lamps)
  );

  slm_pwm #(
    .TimerBits(TimerBits)
  ) u_pwm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .level_i    (level),
    .phase_len_i(phase_q),
    .drive_o    (drive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q    <= level;
      lamps_q    <= lamps;
      drive_q    <= drive;
      smoothed_q <= filt_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign lamp_bits_o = lamps_q;
  assign drive_a_o   = drive_q.a;
  assign drive_b_o   = drive_q.b;
  assign smoothed_o  = smoothed_q;

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  a_lamps_match_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((level_o == '0 && lamp_bits_o == '0) ||
                     (level_o != '0 && $onehot(lamp_bits_o))))
    else $error("lamp pattern does not match level");

  a_drives_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_a_o && drive_b_o))
    else $error("both drives active");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

// ===== tb/slm_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_meter_checker
// Watches the sample, result and register channels of the level meter. Keeps
// its own copy of the average, pwm count, phase timer, duties and registers,
// works out each reading when a sample item is taken, and compares every
// result item field by field with the oldest reading still pending.
// ----------------------------------------------------------------------------
module slm_meter_checker import slm_pkg::*; #(
  parameter int unsigned FractionBits = 8,
  parameter int unsigned TimerBits    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [LevelW-1:0]  level_i,
  input  logic [LampW-1:0]   lamp_bits_i,
  input  logic               drive_a_i,
  input  logic               drive_b_i,
  input  logic [FiltW-1:0]   smoothed_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PhaseW-1:0]  cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [LampW-1:0]  lamps;
    logic              drive_a;
    logic              drive_b;
    logic [FiltW-1:0]  smoothed;
  } meter_reading_t;

  logic [GainW-1:0]     gain_q;
  logic [PhaseW-1:0]    phase_len_q;
  logic [FiltW-1:0]     avg_q;
  logic [PwmCountW-1:0] pwm_cnt_q;
  logic [TimerBits-1:0] phase_tmr_q;
  logic [LevelW-1:0]    duty_a_q;
  logic [LevelW-1:0]    duty_b_q;

  meter_reading_t pending_readings[$];
  meter_reading_t want_r;
  meter_reading_t got_r;
  meter_reading_t next_r;
  int unsigned    fault_cnt;

  task automatic advance_meter(input logic [SampleW-1:0] s, output meter_reading_t r);
    longint         g;
    longint         diff;
    longint         nxt;
    logic [LevelW-1:0] lvl;
    int             i;
    g    = (gain_q > GainMax) ? longint'(GainMax) : longint'(gain_q);
    diff = (longint'(s) << FractionBits) - longint'(avg_q);
    // arithmetic shift of a signed product rounds toward minus infinity
    nxt  = longint'(avg_q) + ((g * diff) >>> GainShift);
    if (nxt < 0) nxt = 0;
    if (nxt > longint'(FiltMax)) nxt = longint'(FiltMax);
    avg_q = nxt[FiltW-1:0];

    lvl = '0;
    for (i = 0; i < NumLevels; i++) begin
      if (longint'(avg_q) > (longint'(LevelThr[i]) << FractionBits)) lvl = LevelW'(i + 1);
    end

    if (pwm_cnt_q > PwmLast) begin
      pwm_cnt_q = '0;
      if (longint'(phase_tmr_q) <= longint'(phase_len_q)) begin
        duty_a_q = lvl;
        duty_b_q = '0;
      end else if (longint'(phase_tmr_q) <= 2 * longint'(phase_len_q)) begin
        duty_b_q = lvl;
        duty_a_q = '0;
      end else begin
        phase_tmr_q = '0;
      end
    end

    r.level    = lvl;
    r.lamps    = (lvl == 0) ? '0 : (LampW'(1) << (lvl - 1));
    r.drive_a  = duty_a_q > pwm_cnt_q;
    r.drive_b  = duty_b_q > pwm_cnt_q;
    r.smoothed = avg_q;

    pwm_cnt_q   = pwm_cnt_q + 1'b1;
    phase_tmr_q = phase_tmr_q + 1'b1;
  endtask

  task automatic flag_fault(input string what, input longint want, input longint got);
    fault_cnt++;
    if (fault_cnt <= 10) $display("mismatch on %0s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      = GainReset;
      phase_len_q = PhaseReset;
      avg_q       = '0;
      pwm_cnt_q   = '0;
      phase_tmr_q = '0;
      duty_a_q    = '0;
      duty_b_q    = '0;
      fault_cnt   = 0;
      pending_readings.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_r = '{level_i, lamp_bits_i, drive_a_i, drive_b_i, smoothed_i};
        if (pending_readings.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10) $display("result item with no sample pending: smoothed %0d",
                                        smoothed_i);
        end else begin
          want_r = pending_readings.pop_front();
          if (got_r.level !== want_r.level) flag_fault("level", want_r.level, got_r.level);
          if (got_r.lamps !== want_r.lamps) flag_fault("lamp_bits", want_r.lamps, got_r.lamps);
          if (got_r.drive_a !== want_r.drive_a) flag_fault("drive_a", want_r.drive_a, got_r.drive_a);
          if (got_r.drive_b !== want_r.drive_b) flag_fault("drive_b", want_r.drive_b, got_r.drive_b);
          if (got_r.smoothed !== want_r.smoothed) begin
            flag_fault("smoothed", want_r.smoothed, got_r.smoothed);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgSmoothingGain: gain_q = cfg_data_i[GainW-1:0];
          CfgPhaseLength:   phase_len_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        advance_meter(sample_i, next_r);
        pending_readings.push_back(next_r);
      end
      errors_o  <= fault_cnt;
      pending_o <= pending_readings.size();
    end
  end

endmodule

// ===== tb/smoothed_level_meter_pwm_alternator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_level_meter_pwm_alternator_tb
// Drives samples and register writes into the level meter and lets the
// checker compare every result item. A short directed run walks the level
// thresholds and gain extremes, then random phases vary gain, phase length
// and idling on both channels, including a long result stall.
// ----------------------------------------------------------------------------
module smoothed_level_meter_pwm_alternator_tb;
  import slm_pkg::*;

  localparam int unsigned FractionBits = 8;
  localparam int unsigned TimerBits    = 25;
  localparam int unsigned ClkPeriod    = 4;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RunPhases    = 12;
  localparam int unsigned PhaseItems   = 115;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned DrainCycles  = 8;

  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [LevelW-1:0]  level_o;
  logic [LampW-1:0]   lamp_bits_o;
  logic               drive_a_o;
  logic               drive_b_o;
  logic [FiltW-1:0]   smoothed_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PhaseW-1:0]  cfg_data_i;

  int unsigned fault_total;
  int unsigned in_flight;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned hold_token;
  int unsigned hold_served;
  int unsigned cycle_cnt = 0;

  logic [SampleW-1:0] probe_samples [20] = '{
    8'd0, 8'd255, 8'd0, 8'd10, 8'd11, 8'd30, 8'd31, 8'd60, 8'd61, 8'd90,
    8'd91, 8'd120, 8'd121, 8'd150, 8'd151, 8'd180, 8'd181, 8'd210, 8'd211, 8'd255
  };

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  smoothed_level_meter_pwm_alternator #(
    .FractionBits(FractionBits),
    .TimerBits   (TimerBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .level_o    (level_o),
    .lamp_bits_o(lamp_bits_o),
    .drive_a_o  (drive_a_o),
    .drive_b_o  (drive_b_o),
    .smoothed_o (smoothed_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  slm_meter_checker #(
    .FractionBits(FractionBits),
    .TimerBits   (TimerBits)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .sample_i   (sample_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .level_i    (level_o),
    .lamp_bits_i(lamp_bits_o),
    .drive_a_i  (drive_a_o),
    .drive_b_i  (drive_b_o),
    .smoothed_i (smoothed_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .errors_o   (fault_total),
    .pending_o  (in_flight)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold whenever a new token shows up
  initial begin
    out_ready_i = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_served) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_served = hold_token;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_sample(input logic [SampleW-1:0] s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PhaseW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned       ph;
    int unsigned       k;
    int unsigned       run_left;
    int unsigned       run_kind;
    logic [SampleW-1:0] run_val;
    logic [SampleW-1:0] s;
    logic [GainW-1:0]  gn;
    logic [PhaseW-1:0] pl;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgSmoothingGain;
    cfg_data_i   = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_token   = 0;
    run_left     = 0;
    run_kind     = 0;
    run_val      = '0;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full gain: average tracks the sample, walk both sides of each threshold
    write_reg(CfgSmoothingGain, PhaseW'(GainMax));
    write_reg(CfgPhaseLength, '0);
    cfg_valid_i <= 1'b0;
    foreach (probe_samples[i]) push_sample(probe_samples[i]);

    // gain above full scale, upper data bits set
    wait_drained();
    write_reg(CfgSmoothingGain, '1);
    cfg_valid_i <= 1'b0;
    push_sample(8'd0);
    push_sample(8'd200);

    // zero gain freezes the average
    wait_drained();
    write_reg(CfgSmoothingGain, '0);
    cfg_valid_i <= 1'b0;
    push_sample(8'd255);
    push_sample(8'd128);

    for (ph = 0; ph < RunPhases; ph++) begin
      wait_drained();
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 46; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 46; end
        default: begin send_gap_pct = 12; stall_pct = 12; end
      endcase

      case ($urandom_range(6))
        0: gn = '0;
        1: gn = GainW'(1);
        2: gn = GainMax;
        3: gn = GainW'($urandom_range(511, 257));
        4: gn = GainReset;
        default: gn = GainW'($urandom_range(255, 2));
      endcase
      case ($urandom_range(6))
        0: pl = '0;
        1: pl = PhaseW'(1);
        2: pl = '1;
        3: pl = PhaseReset;
        4: pl = PhaseW'($urandom);
        default: pl = PhaseW'($urandom_range(60, 2));
      endcase
      write_reg(CfgSmoothingGain, {(PhaseW - GainW)'($urandom), gn});
      write_reg(CfgPhaseLength, pl);
      if (ph % 3 == 2) begin
        write_reg(CfgSpareLo, PhaseW'($urandom));
        write_reg(CfgSpareHi, PhaseW'($urandom));
      end
      cfg_valid_i <= 1'b0;

      if (ph == 4) hold_token = hold_token + 1;

      for (k = 0; k < PhaseItems; k++) begin
        if (run_left == 0) begin
          run_kind = $urandom_range(3);
          run_left = $urandom_range(40, 4);
          run_val  = SampleW'($urandom);
        end
        case (run_kind)
          0: s = run_val;
          1: s = SampleW'($urandom);
          2: s = $urandom_range(1) ? '1 : '0;
          default: s = run_val ^ SampleW'($urandom_range(3));
        endcase
        run_left = run_left - 1;
        push_sample(s);
        if ($urandom_range(199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fault_total == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/slm_pkg.sv
rtl/core/slm_filter.sv
rtl/core/slm_level.sv
rtl/core/slm_pwm.sv
rtl/core/smoothed_level_meter_pwm_alternator.sv
tb/slm_meter_checker.sv
tb/smoothed_level_meter_pwm_alternator_tb.sv
